[hdl/keystream_seal_with_fnv_check_defines.svh]
// ----------------------------------------------------------------------------
// keystream sealer assertion macros
// shared concurrent assertion forms, clocked on clk and idle during reset
// ----------------------------------------------------------------------------
`ifndef KEYSTREAM_SEAL_WITH_FNV_CHECK_DEFINES_SVH
`define KEYSTREAM_SEAL_WITH_FNV_CHECK_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define KSFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ksfc_pkg.sv]
// ----------------------------------------------------------------------------
// ksfc_pkg
// constants, command and status types shared by the keystream sealer
// ----------------------------------------------------------------------------
`default_nettype none

package ksfc_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEAL_MODE = 2'd1;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
    localparam logic [63:0] KEY_A    = 64'h9F3ADB27C41E88B5;
    localparam logic [63:0] KEY_B    = 64'h51C2F97A6E0D3B84;
    localparam logic [63:0] KEY_C    = 64'h2D6F8B1A94C5E037;

    // fixed generator key, folded at elaboration
    localparam logic [63:0] KEY_MIX0 = ((KEY_A ^ KEY_B) + SM_GAMMA) ^ KEY_C;
    localparam logic [63:0] KEY_MIX1 = KEY_MIX0 * SM_MUL1;
    localparam logic [63:0] SEAL_KEY = KEY_MIX1 ^ (KEY_MIX1 >> 29);

    // partial product selection of the shared 32x32 multiplier
    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_LO_HI,
        MUL_HI_LO
    } ksfc_mul_phase_t;

    typedef struct packed {
        logic            restart;
        logic            gen_step;
        logic            mul_en;
        ksfc_mul_phase_t mul_phase;
        logic            mul_second;
        logic            mix_load;
        logic            word_load;
        logic            byte_take;
        logic            csum_take;
        logic [1:0]      csum_idx;
    } ksfc_cmd_t;

    typedef struct packed {
        logic seal;
        logic lane_wrap;
        logic out_free;
        logic cfg_write;
    } ksfc_stat_t;

endpackage

`default_nettype wire

[hdl/ksfc_ctrl.sv]
// ----------------------------------------------------------------------------
// ksfc_ctrl
// sequencer: keystream word build, byte transactions and checksum trailer
// ----------------------------------------------------------------------------
`default_nettype none

`include "keystream_seal_with_fnv_check_defines.svh"

module ksfc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire ksfc_pkg::ksfc_stat_t stat,
    output ksfc_pkg::ksfc_cmd_t      cmd
);
    import ksfc_pkg::*;

    typedef enum logic [3:0] {
        S_GEN,
        S_MA0,
        S_MA1,
        S_MA2,
        S_MIX,
        S_MB0,
        S_MB1,
        S_MB2,
        S_FIN,
        S_RUN,
        S_CSUM
    } state_t;

    state_t     state_reg, state_next;
    logic       csum_pending_reg, csum_pending_next;
    logic [1:0] csum_idx_reg, csum_idx_next;
    logic       take;

    assign in_ready = (state_reg == S_RUN) && stat.out_free;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next        = state_reg;
        csum_pending_next = csum_pending_reg;
        csum_idx_next     = csum_idx_reg;
        cmd               = '0;
        cmd.mul_phase     = MUL_LO_LO;
        cmd.csum_idx      = csum_idx_reg;

        unique case (state_reg)
            S_GEN:
            begin
                cmd.gen_step = 1'b1;
                state_next   = S_MA0;
            end
            S_MA0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_LO;
                state_next    = S_MA1;
            end
            S_MA1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_LO_HI;
                state_next    = S_MA2;
            end
            S_MA2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = MUL_HI_LO;
                state_next    = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix_load = 1'b1;
                state_next   = S_MB0;
            end
            S_MB0:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_second = 1'b1;
                cmd.mul_phase  = MUL_LO_LO;
                state_next     = S_MB1;
            end
            S_MB1:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_second = 1'b1;
                cmd.mul_phase  = MUL_LO_HI;
                state_next     = S_MB2;
            end
            S_MB2:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_second = 1'b1;
                cmd.mul_phase  = MUL_HI_LO;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                cmd.word_load = 1'b1;
                state_next    = csum_pending_reg ? S_CSUM : S_RUN;
            end
            S_RUN:
            begin
                if (take)
                begin
                    cmd.byte_take = 1'b1;
                    if (in_last && stat.seal)
                    begin
                        csum_pending_next = 1'b1;
                        csum_idx_next     = 2'd0;
                        state_next        = stat.lane_wrap ? S_GEN : S_CSUM;
                    end
                    else if (in_last)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_GEN;
                    end
                    else if (stat.lane_wrap)
                    begin
                        state_next = S_GEN;
                    end
                end
            end
            S_CSUM:
            begin
                if (stat.out_free)
                begin
                    cmd.csum_take = 1'b1;
                    if (csum_idx_reg == 2'd3)
                    begin
                        // trailer done, start over for the next payload
                        cmd.restart       = 1'b1;
                        csum_pending_next = 1'b0;
                        csum_idx_next     = 2'd0;
                        state_next        = S_GEN;
                    end
                    else
                    begin
                        csum_idx_next = csum_idx_reg + 2'd1;
                        state_next    = stat.lane_wrap ? S_GEN : S_CSUM;
                    end
                end
            end
            default:
            begin
                state_next = S_GEN;
            end
        endcase

        // a nonce or seal-mode register write abandons everything and rebuilds the first word
        if (stat.cfg_write)
        begin
            state_next        = S_GEN;
            csum_pending_next = 1'b0;
            csum_idx_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_GEN;
            csum_pending_reg <= 1'b0;
            csum_idx_reg     <= 2'd0;
        end
        else
        begin
            state_reg        <= state_next;
            csum_pending_reg <= csum_pending_next;
            csum_idx_reg     <= csum_idx_next;
        end
    end

    `KSFC_ASSERT_NEXT(a_seal_last_holds_input, take && stat.seal && in_last, !in_ready, "input taken during checksum trailer")
    `KSFC_ASSERT_NOW(a_idx_needs_pending, csum_idx_reg != 2'd0, csum_pending_reg, "checksum index without pending trailer")
    `KSFC_ASSERT_NEXT(a_fin_resumes, (state_reg == S_FIN) && !stat.cfg_write, (state_reg == S_RUN) || (state_reg == S_CSUM), "word build did not resume traffic")

endmodule

`default_nettype wire

[hdl/ksfc_datapath.sv]
// ----------------------------------------------------------------------------
// ksfc_datapath
// generator, shared multiplier, fnv hash, tail window and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "keystream_seal_with_fnv_check_defines.svh"

module ksfc_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ksfc_pkg::ksfc_cmd_t           cmd,
    output ksfc_pkg::ksfc_stat_t               stat,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_byte,
    output logic                               out_last,
    output logic                               checksum_good,
    output logic                               payload_short,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ksfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data
);
    import ksfc_pkg::*;

    // control state
    logic [63:0] nonce_reg, nonce_next;
    logic        seal_reg, seal_next;
    logic [63:0] gen_reg, gen_next;
    logic [2:0]  lane_reg, lane_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  count_reg, count_next;
    logic        out_valid_reg, out_valid_next;

    // payload
    logic [63:0] word_reg, word_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        good_reg, good_next;
    logic        short_reg, short_next;

    logic [7:0]  key_byte;
    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic [63:0] gen_sum;
    logic [7:0]  hash_src;
    logic [31:0] hash_mix;
    logic [31:0] hash_after;
    logic [7:0]  plain;
    logic        count_sat;
    logic [2:0]  count_inc;
    logic [31:0] window_shift;
    logic [7:0]  csum_byte;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid
                       && ((cfg_index == CFG_NONCE) || (cfg_index == CFG_SEAL_MODE));

    assign stat.seal      = seal_reg;
    assign stat.lane_wrap = (lane_reg == 3'd7);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.cfg_write = cfg_write;

    assign key_byte  = word_reg[{lane_reg, 3'b000} +: 8];
    assign mul_const = cmd.mul_second ? SM_MUL2 : SM_MUL1;

    always_comb
    begin
        unique case (cmd.mul_phase)
            MUL_LO_LO:
            begin
                mul_a = opa_reg[31:0];
                mul_b = mul_const[31:0];
            end
            MUL_LO_HI:
            begin
                mul_a = opa_reg[31:0];
                mul_b = mul_const[63:32];
            end
            MUL_HI_LO:
            begin
                mul_a = opa_reg[63:32];
                mul_b = mul_const[31:0];
            end
            default:
            begin
                mul_a = opa_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    assign mul_prod     = {32'd0, mul_a} * {32'd0, mul_b};
    assign gen_sum      = gen_reg + SM_GAMMA;
    assign hash_src     = seal_reg ? in_byte : window_reg[7:0];
    assign hash_mix     = (hash_reg ^ {24'd0, hash_src}) * FNV_PRIME;
    assign plain        = in_byte ^ key_byte;
    assign count_sat    = (count_reg == 3'd4);
    assign count_inc    = count_sat ? count_reg : count_reg + 3'd1;
    assign window_shift = {plain, window_reg[31:8]};
    // unseal hashes the byte leaving the window only once the window is full
    assign hash_after   = count_sat ? hash_mix : hash_reg;
    assign csum_byte    = hash_reg[{cmd.csum_idx, 3'b000} +: 8] ^ key_byte;

    always_comb
    begin
        nonce_next     = nonce_reg;
        seal_next      = seal_reg;
        gen_next       = gen_reg;
        lane_next      = lane_reg;
        hash_next      = hash_reg;
        window_next    = window_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        opa_next       = opa_reg;
        acc_next       = acc_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        good_next      = good_reg;
        short_next     = short_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.gen_step)
        begin
            gen_next = gen_sum;
            opa_next = gen_sum ^ (gen_sum >> 30);
        end

        // 64-bit product mod 2^64 from three 32x32 partial products
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == MUL_LO_LO)
            begin
                acc_next = mul_prod;
            end
            else
            begin
                acc_next = {acc_reg[63:32] + mul_prod[31:0], acc_reg[31:0]};
            end
        end

        if (cmd.mix_load)
        begin
            opa_next = acc_reg ^ (acc_reg >> 27);
        end

        if (cmd.word_load)
        begin
            word_next = acc_reg ^ (acc_reg >> 31);
        end

        if (cmd.byte_take)
        begin
            lane_next      = lane_reg + 3'd1;
            out_valid_next = 1'b1;
            if (seal_reg)
            begin
                hash_next     = hash_mix;
                out_byte_next = in_byte ^ key_byte;
                out_last_next = 1'b0;
                good_next     = 1'b0;
                short_next    = 1'b0;
            end
            else
            begin
                hash_next     = hash_after;
                window_next   = window_shift;
                count_next    = count_inc;
                out_byte_next = plain;
                out_last_next = in_last;
                good_next     = in_last && (count_inc == 3'd4) && (window_shift == hash_after);
                short_next    = in_last && (count_inc != 3'd4);
            end
        end

        if (cmd.csum_take)
        begin
            lane_next      = lane_reg + 3'd1;
            out_valid_next = 1'b1;
            out_byte_next  = csum_byte;
            out_last_next  = (cmd.csum_idx == 2'd3);
            good_next      = 1'b0;
            short_next     = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NONCE:     nonce_next = cfg_data;
                CFG_SEAL_MODE: seal_next  = cfg_data[0];
                default:       nonce_next = nonce_reg;
            endcase
        end

        if (cmd.restart || cfg_write)
        begin
            gen_next    = SEAL_KEY ^ nonce_next;
            lane_next   = 3'd0;
            hash_next   = FNV_BASIS;
            window_next = 32'd0;
            count_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonce_reg     <= 64'd0;
            seal_reg      <= 1'b0;
            gen_reg       <= SEAL_KEY;
            lane_reg      <= 3'd0;
            hash_reg      <= FNV_BASIS;
            window_reg    <= 32'd0;
            count_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nonce_reg     <= nonce_next;
            seal_reg      <= seal_next;
            gen_reg       <= gen_next;
            lane_reg      <= lane_next;
            hash_reg      <= hash_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        opa_reg      <= opa_next;
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        good_reg     <= good_next;
        short_reg    <= short_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign checksum_good = good_reg;
    assign payload_short = short_reg;

    `KSFC_ASSERT_NOW(a_count_saturates, 1'b1, count_reg <= 3'd4, "byte count above four")
    `KSFC_ASSERT_NOW(a_good_on_last, out_valid_reg && good_reg, out_last_reg, "checksum flag off the last byte")
    `KSFC_ASSERT_NOW(a_flags_exclusive, out_valid_reg, !(good_reg && short_reg), "good and short both set")

endmodule

`default_nettype wire

[hdl/keystream_seal_with_fnv_check.sv]
// ----------------------------------------------------------------------------
// keystream_seal_with_fnv_check
// splitmix64 keystream byte cipher with fnv-1a 32 seal and verify
// ----------------------------------------------------------------------------
// Bytes stream in one transaction at a time and leave through a single output
// register, so a new byte is taken in the same cycle a waiting result is
// taken. While a 64-bit keystream word lasts and the receiver does not stall,
// one byte moves per cycle. Each word serves eight bytes; the next one is built
// by one shared 32x32 multiplier (add step, two 64-bit products of three partial
// products each, two mix steps). In seal mode the last byte is followed by four
// checksum bytes at one per cycle while the receiver does not stall, with a word
// build in between wherever the keystream word runs out, and no input taken
// meanwhile. After every last byte (in seal mode, after its trailer) and after
// every nonce or seal-mode register write, the generator, hash and window start
// over and the first word is rebuilt before input resumes.
// ----------------------------------------------------------------------------
`default_nettype none

module keystream_seal_with_fnv_check (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        in_byte,
    input  wire logic                              in_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_byte,
    output logic                                   out_last,
    output logic                                   checksum_good,
    output logic                                   payload_short,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ksfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [63:0]                       cfg_data
);
    import ksfc_pkg::*;

    ksfc_cmd_t  cmd;
    ksfc_stat_t stat;

    ksfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ksfc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .checksum_good (checksum_good),
        .payload_short (payload_short),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the keystream sealer byte for byte against a predictor of its own:
// a directed table of edge cases, then random payloads in both modes under
// changing sender and receiver idling, a long receiver hold-off and
// register writes that restart the generator
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksfc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int END_CYCLES    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 300000;

    // fixed generator key, folded from the key words
    localparam logic [63:0] KEY_FOLD0 = ((KEY_A ^ KEY_B) + SM_GAMMA) ^ KEY_C;
    localparam logic [63:0] KEY_FOLD1 = KEY_FOLD0 * SM_MUL1;
    localparam logic [63:0] FIXED_KEY = KEY_FOLD1 ^ (KEY_FOLD1 >> 29);

    typedef logic [7:0] octet_q_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       good;
        logic       shrt;
    } cipher_out_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_t;

    // typed flags: {use, out_last, checksum_good, payload_short}
    typedef struct packed {
        row_kind_t              kind;
        logic [7:0]             data8;
        logic                   last;
        logic [CFG_INDEX_W-1:0] idx;
        logic [63:0]            wdata;
        logic [3:0]             flags;
    } dir_row_t;

    localparam int DIR_ROWS = 31;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_BYTE, 8'h00, 1'b1, CFG_NONCE, 64'd0, 4'b1101},
        '{ROW_BYTE, 8'hff, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h80, 1'b1, CFG_NONCE, 64'd0, 4'b1101},
        '{ROW_BYTE, 8'h01, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h02, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h04, 1'b1, CFG_NONCE, 64'd0, 4'b1101},
        '{ROW_REG,  8'h00, 1'b0, CFG_SEAL_MODE, 64'd1, 4'b0000},
        '{ROW_BYTE, 8'hff, 1'b1, CFG_NONCE, 64'd0, 4'b1000},
        '{ROW_REG,  8'h00, 1'b0, CFG_NONCE, 64'hffff_ffff_ffff_ffff, 4'b0000},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_NONCE, 64'd0, 4'b1000},
        '{ROW_BYTE, 8'h7f, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'hfe, 1'b1, CFG_NONCE, 64'd0, 4'b1000},
        '{ROW_REG,  8'h00, 1'b0, CFG_SEAL_MODE, 64'd0, 4'b0000},
        // nine bytes run across a keystream word boundary
        '{ROW_BYTE, 8'h00, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'hff, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h55, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'haa, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h0f, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'hf0, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h33, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'hcc, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h96, 1'b1, CFG_NONCE, 64'd0, 4'b0000},
        // nonce write drops the partial payload, so the next byte stands alone
        '{ROW_BYTE, 8'h11, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h22, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_REG,  8'h00, 1'b0, CFG_NONCE, 64'h0123_4567_89ab_cdef, 4'b0000},
        '{ROW_BYTE, 8'h33, 1'b1, CFG_NONCE, 64'd0, 4'b1101},
        // write to an unused index keeps the partial payload going
        '{ROW_BYTE, 8'ha5, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h5a, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_REG,  8'h00, 1'b0, CFG_UNUSED, 64'h5555_aaaa_5555_aaaa, 4'b0000},
        '{ROW_BYTE, 8'hc3, 1'b0, CFG_NONCE, 64'd0, 4'b0000},
        '{ROW_BYTE, 8'h3c, 1'b1, CFG_NONCE, 64'd0, 4'b0000}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte = 8'd0;
    logic                   in_last = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_byte;
    logic                   out_last;
    logic                   checksum_good;
    logic                   payload_short;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = 64'd0;

    // typed flags travel with the byte they belong to
    logic [3:0] row_flags = 4'b0000;

    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_token = 1'b0;
    logic hold_seen = 1'b0;
    int  hold_left = 0;
    int  fail_count = 0;
    int  cycle_count = 0;

    // predictor state
    logic [63:0] ks_nonce;
    logic        seal_on;
    logic [63:0] ks_gen;
    logic [63:0] ks_word;
    logic [2:0]  ks_lane;
    logic [31:0] fnv_hash;
    logic [31:0] tail_window_q;
    logic [2:0]  tail_count;

    cipher_out_t expected_out[$];

    keystream_seal_with_fnv_check u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .checksum_good (checksum_good),
        .payload_short (payload_short),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] splitmix_mix(input logic [63:0] s);
        logic [63:0] z;
        z = s;
        z = (z ^ (z >> 30)) * SM_MUL1;
        z = (z ^ (z >> 27)) * SM_MUL2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    // ciphertext of a well-formed sealed payload, from a fresh generator
    function automatic octet_q_t seal_bytes(input logic [63:0] nonce_v, input octet_q_t plain);
        octet_q_t    full;
        octet_q_t    enc;
        logic [31:0] h;
        logic [63:0] kw;
        int          j;
        full = plain;
        h = FNV_BASIS;
        foreach (plain[k])
            h = fnv_step(h, plain[k]);
        for (j = 0; j < 4; j++)
            full = {full, h[8*j +: 8]};
        for (j = 0; j < full.size(); j++)
        begin
            kw = splitmix_mix((FIXED_KEY ^ nonce_v) + SM_GAMMA * 64'(j / 8 + 1));
            enc = {enc, full[j] ^ kw[8*(j % 8) +: 8]};
        end
        return enc;
    endfunction

    task automatic restart_stream();
        ks_gen = FIXED_KEY ^ ks_nonce;
        ks_word = 64'd0;
        ks_lane = 3'd0;
        fnv_hash = FNV_BASIS;
        tail_window_q = 32'd0;
        tail_count = 3'd0;
    endtask

    task automatic next_key_byte(output logic [7:0] kb);
        if (ks_lane == 3'd0)
        begin
            ks_gen = ks_gen + SM_GAMMA;
            ks_word = splitmix_mix(ks_gen);
        end
        kb = ks_word[8*ks_lane +: 8];
        ks_lane = ks_lane + 3'd1;
    endtask

    task automatic apply_reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            CFG_NONCE:
            begin
                ks_nonce = data;
                restart_stream();
            end
            CFG_SEAL_MODE:
            begin
                seal_on = data[0];
                restart_stream();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_cipher_byte(input logic [7:0] b, input logic last,
                                       input logic [3:0] flags);
        logic [7:0]  kb;
        logic [7:0]  plain;
        logic [31:0] h;
        cipher_out_t r;
        int          i;
        next_key_byte(kb);
        if (seal_on)
        begin
            fnv_hash = fnv_step(fnv_hash, b);
            r.data = b ^ kb;
            r.last = 1'b0;
            r.good = 1'b0;
            r.shrt = 1'b0;
        end
        else
        begin
            plain = b ^ kb;
            if (tail_count >= 3'd4)
                fnv_hash = fnv_step(fnv_hash, tail_window_q[7:0]);
            tail_window_q = {plain, tail_window_q[31:8]};
            if (tail_count < 3'd4)
                tail_count = tail_count + 3'd1;
            r.data = plain;
            r.last = last;
            r.good = last && tail_count == 3'd4 && tail_window_q == fnv_hash;
            r.shrt = last && tail_count < 3'd4;
        end
        if (flags[3])
            {r.last, r.good, r.shrt} = flags[2:0];
        expected_out = {expected_out, r};
        if (seal_on && last)
        begin
            h = fnv_hash;
            for (i = 0; i < 4; i++)
            begin
                next_key_byte(kb);
                r.data = h[8*i +: 8] ^ kb;
                r.last = (i == 3);
                r.good = 1'b0;
                r.shrt = 1'b0;
                expected_out = {expected_out, r};
            end
        end
        if (last)
            restart_stream();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // predictor and checker, on the values seen at the rising edge
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_cipher_byte(in_byte, in_last, row_flags);
            if (out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                    report_mismatch("unexpected transaction", 64'(out_byte), 64'd0);
                else
                begin
                    want = expected_out.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", 64'(out_byte), 64'(want.data));
                    if (out_last !== want.last)
                        report_mismatch("out_last", 64'(out_last), 64'(want.last));
                    if (checksum_good !== want.good)
                        report_mismatch("checksum_good", 64'(checksum_good),
                                        64'(want.good));
                    if (payload_short !== want.shrt)
                        report_mismatch("payload_short", 64'(payload_short),
                                        64'(want.shrt));
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // returns at the rising edge where the byte was taken
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [3:0] flags);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        row_flags <= flags;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        drain_results();
        // the block rebuilds its first keystream word after each last byte
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_payload(input octet_q_t pl, input logic close);
        foreach (pl[i])
            send_byte(pl[i], close && i == pl.size() - 1, 4'b0000);
    endtask

    // mostly well-formed sealed payloads when unsealing, the rest noise
    task automatic run_payloads(input int target_bytes);
        octet_q_t pl;
        octet_q_t plain;
        int       sent;
        int       pick;
        int       n;
        sent = 0;
        while (sent < target_bytes)
        begin
            pl = {};
            plain = {};
            pick = $urandom_range(99);
            if (seal_on || pick >= 90)
                n = seal_on ? $urandom_range(1, 12) : $urandom_range(4, 12);
            else if (pick >= 80)
                n = $urandom_range(1, 3);
            else
                n = 0;
            repeat (n) pl = {pl, 8'($urandom_range(255))};
            if (!seal_on && pick < 80)
            begin
                repeat ($urandom_range(0, 8)) plain = {plain, 8'($urandom_range(255))};
                pl = seal_bytes(ks_nonce, plain);
                if (pick >= 65)
                    pl[$urandom_range(pl.size() - 1)] ^= 8'(1 << $urandom_range(7));
            end
            send_payload(pl, 1'b1);
            sent += pl.size();
        end
    endtask

    initial
    begin
        int       send_pct [4];
        int       stall_pct [4];
        octet_q_t partial;
        send_pct = '{0, 53, 0, 6};
        stall_pct = '{0, 0, 53, 6};
        ks_nonce = 64'd0;
        seal_on = 1'b0;
        restart_stream();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].idx, dir_rows[i].wdata);
            else
                send_byte(dir_rows[i].data8, dir_rows[i].last, dir_rows[i].flags);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_NONCE, {$urandom, $urandom});
            write_reg(CFG_SEAL_MODE, 64'(ph % 2));
            sender_idle_pct = send_pct[ph];
            recv_stall_pct <= stall_pct[ph];
            run_payloads(6);
            drain_results();
            run_payloads(6);
            // sometimes leave a payload open for the next register write to drop
            if ($urandom_range(1) == 1)
            begin
                partial = {};
                repeat ($urandom_range(1, 5)) partial = {partial, 8'($urandom_range(255))};
                send_payload(partial, 1'b0);
            end
        end

        // receiver holds off while the sender keeps offering
        write_reg(CFG_SEAL_MODE, 64'd1);
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_token <= ~hold_token;
        run_payloads(8);

        drain_results();
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
